FILE: hdl/tbec_pkg.sv
`timescale 1ns / 1ps
// Package for the three-button event classifier.
// Holds the event codes, register indexes, reset values and the state type.
// Has no dependencies.
package tbec_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 16;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_ENTER_SHORT = 3'd1,
        EV_ENTER_LONG  = 3'd2,
        EV_LEFT        = 3'd3,
        EV_RIGHT       = 3'd4
    } t_event;

    typedef enum logic {
        REG_REPEAT_INTERVAL = 1'b0,
        REG_LONG_PRESS      = 1'b1
    } t_reg_index;

    localparam logic [CfgW-1:0] RepeatReset = 16'd180;
    localparam logic [CfgW-1:0] LongReset   = 16'd900;

    typedef struct packed {
        logic [TimeW-1:0] enter_start_time;
        logic             enter_long_sent;
        logic [TimeW-1:0] left_fire_time;
        logic [TimeW-1:0] right_fire_time;
    } t_state;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             left_pressed;
        logic             enter_pressed;
        logic             right_pressed;
    } t_poll;

endpackage

FILE: hdl/tbec_core.sv
`timescale 1ns / 1ps
// Combinational classifier for one poll: next state and event.
// Depends on tbec_pkg.
module tbec_core
    import tbec_pkg::*;
(
    input  t_poll           i_poll,
    input  t_state          i_state,
    input  logic [CfgW-1:0] i_repeat_interval_ms,
    input  logic [CfgW-1:0] i_long_press_ms,
    output t_state          o_state,
    output t_event          o_event
);

    logic [TimeW-1:0] enter_age;
    logic [TimeW-1:0] left_age;
    logic [TimeW-1:0] right_age;
    logic             long_due;
    logic             left_due;
    logic             right_due;
    t_event           enter_event;

    assign enter_age = i_poll.now_ms - i_state.enter_start_time;
    assign left_age  = i_poll.now_ms - i_state.left_fire_time;
    assign right_age = i_poll.now_ms - i_state.right_fire_time;
    assign long_due  = enter_age >= {{(TimeW-CfgW){1'b0}}, i_long_press_ms};
    assign left_due  = left_age >= {{(TimeW-CfgW){1'b0}}, i_repeat_interval_ms};
    assign right_due = right_age >= {{(TimeW-CfgW){1'b0}}, i_repeat_interval_ms};

    always_comb begin
        o_state     = i_state;
        enter_event = EV_NONE;
        if (i_poll.enter_pressed) begin
            if (i_state.enter_start_time == '0) begin
                o_state.enter_start_time = (i_poll.now_ms == '0) ?
                                           {{(TimeW-1){1'b0}}, 1'b1} : i_poll.now_ms;
                o_state.enter_long_sent  = 1'b0;
            end else if (!i_state.enter_long_sent && long_due) begin
                o_state.enter_long_sent = 1'b1;
                enter_event             = EV_ENTER_LONG;
            end
        end else begin
            if (i_state.enter_start_time != '0 && !i_state.enter_long_sent) begin
                enter_event = EV_ENTER_SHORT;
            end
            o_state.enter_start_time = '0;
            o_state.enter_long_sent  = 1'b0;
        end

        o_event = enter_event;
        if (enter_event == EV_NONE) begin
            priority if (i_poll.left_pressed && left_due) begin
                o_state.left_fire_time = i_poll.now_ms;
                o_event                = EV_LEFT;
            end else if (i_poll.right_pressed && right_due) begin
                o_state.right_fire_time = i_poll.now_ms;
                o_event                 = EV_RIGHT;
            end
        end
    end

endmodule

FILE: hdl/three_button_event_classifier.sv
`timescale 1ns / 1ps
// Three-button event classifier: top level with stream ports and APB registers.
// Depends on tbec_pkg and tbec_core.
// The poll is held in the input register and the event in the result register.
// Throughput: one poll per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the output is not taken.
// Reset (synchronous, active low) clears the press and fire times, empties both
// stages and returns the registers to 180 ms and 900 ms.
module three_button_event_classifier
    import tbec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [32] left_pressed, [33] enter_pressed, [34] right_pressed
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] button_event
    output logic [7:0]  m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_in_valid;
    t_poll           r_in;
    logic            r_out_valid;
    t_event          r_event;
    t_state          r_state;
    logic [CfgW-1:0] r_repeat_interval_ms;
    logic [CfgW-1:0] r_long_press_ms;

    t_state          n_state;
    t_event          n_event;
    t_poll           in_poll;
    logic            advance;
    logic            in_take;
    logic            cfg_write;
    t_reg_index      cfg_index;

    assign in_poll.now_ms        = s_axis_tdata[31:0];
    assign in_poll.left_pressed  = s_axis_tdata[32];
    assign in_poll.enter_pressed = s_axis_tdata[33];
    assign in_poll.right_pressed = s_axis_tdata[34];

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    tbec_core u_core (
        .i_poll               (r_in),
        .i_state              (r_state),
        .i_repeat_interval_ms (r_repeat_interval_ms),
        .i_long_press_ms      (r_long_press_ms),
        .o_state              (n_state),
        .o_event              (n_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_poll;
        end
        if (advance && r_in_valid) begin
            r_event <= n_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_event};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_interval_ms <= RepeatReset;
            r_long_press_ms      <= LongReset;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_REPEAT_INTERVAL: r_repeat_interval_ms <= pwdata[CfgW-1:0];
                REG_LONG_PRESS:      r_long_press_ms      <= pwdata[CfgW-1:0];
                default:             ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_REPEAT_INTERVAL: prdata = {16'b0, r_repeat_interval_ms};
            REG_LONG_PRESS:      prdata = {16'b0, r_long_press_ms};
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-button event classifier.
// Drives polls on the stream input and register writes on the APB port, predicts
// every event in a scoreboard class; depends on tbec_pkg and the classifier itself.
module tb_top;
    import tbec_pkg::*;

    localparam int unsigned QuietLimit    = 5000;
    localparam int unsigned HoldOffCycles = 300;
    localparam int unsigned PhaseItems    = 200;
    localparam int unsigned NumPhases     = 8;
    localparam int unsigned DrainCycles   = 4;

    class press_event_scoreboard;
        logic [CfgW-1:0]  repeat_ms;
        logic [CfgW-1:0]  long_ms;
        logic [TimeW-1:0] press_start;
        logic             long_done;
        logic [TimeW-1:0] left_last;
        logic [TimeW-1:0] right_last;
        t_event           expected_events[$];
        int unsigned      errors;

        function new();
            repeat_ms   = RepeatReset;
            long_ms     = LongReset;
            press_start = '0;
            long_done   = 1'b0;
            left_last   = '0;
            right_last  = '0;
            errors      = 0;
        endfunction

        function void set_register(t_reg_index idx, logic [31:0] value);
            if (idx == REG_REPEAT_INTERVAL) begin
                repeat_ms = value[CfgW-1:0];
            end else begin
                long_ms = value[CfgW-1:0];
            end
        endfunction

        function void note_poll(logic [TimeW-1:0] now, logic left, logic enter, logic right);
            t_event           ev;
            logic [TimeW-1:0] held;
            logic [TimeW-1:0] since_left;
            logic [TimeW-1:0] since_right;
            ev = EV_NONE;
            held = now - press_start;
            since_left = now - left_last;
            since_right = now - right_last;
            if (enter) begin
                if (press_start == '0) begin
                    press_start = (now == '0) ? 32'd1 : now;
                    long_done = 1'b0;
                end else if (!long_done && held >= {16'd0, long_ms}) begin
                    long_done = 1'b1;
                    ev = EV_ENTER_LONG;
                end
            end else begin
                if (press_start != '0 && !long_done) begin
                    ev = EV_ENTER_SHORT;
                end
                press_start = '0;
                long_done = 1'b0;
            end
            if (ev == EV_NONE) begin
                if (left && since_left >= {16'd0, repeat_ms}) begin
                    left_last = now;
                    ev = EV_LEFT;
                end else if (right && since_right >= {16'd0, repeat_ms}) begin
                    right_last = now;
                    ev = EV_RIGHT;
                end
            end
            expected_events.push_back(ev);
        endfunction

        function void check_event(logic [2:0] got);
            t_event want;
            if (expected_events.size() == 0) begin
                $error("button_event: expected none pending, actual %0d", got);
                errors++;
            end else begin
                want = expected_events.pop_front();
                if (got !== want) begin
                    $error("button_event: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    press_event_scoreboard sb;
    bit                    hold_req = 1'b0;
    bit                    sender_burst = 1'b0;
    int unsigned           quiet_cycles = 0;

    three_button_event_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (sender_burst) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_poll(logic [31:0] now, logic left, logic enter, logic right,
                             int unsigned gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, right, enter, left, now};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_poll(now, left, enter, right);
    endtask

    // The upper half of the written word is random, since the register keeps 16 bits.
    task automatic write_register(t_reg_index idx, logic [CfgW-1:0] value);
        logic [31:0] word;
        word = {16'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        sb.set_register(idx, word);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_event(m_axis_tdata[2:0]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned stretch;
        logic        level;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    level = 1'b1;
                    stretch = $urandom_range(50, 200);
                end else if (roll < 60) begin
                    level = 1'b1;
                    stretch = $urandom_range(1, 12);
                end else if (roll < 92) begin
                    level = 1'b0;
                    stretch = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    stretch = $urandom_range(10, 40);
                end
                m_axis_tready <= level;
                for (int k = 0; k < stretch && !hold_req; k++) begin
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        logic [31:0]     t;
        logic            key_left;
        logic            key_enter;
        logic            key_right;
        logic [CfgW-1:0] rep;
        logic [CfgW-1:0] lng;
        int unsigned     step_max;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a press at time zero, fire times starting from zero,
        // enter masking left and right, and timestamps that wrap.
        send_poll(32'd0, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'd100, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'd200, 1'b1, 1'b1, 1'b0, pick_gap());
        send_poll(32'd901, 1'b0, 1'b1, 1'b1, pick_gap());
        send_poll(32'd950, 1'b0, 1'b1, 1'b1, pick_gap());
        send_poll(32'd1000, 1'b1, 1'b0, 1'b1, pick_gap());
        send_poll(32'd1010, 1'b0, 1'b1, 1'b0, pick_gap());
        send_poll(32'd1020, 1'b1, 1'b0, 1'b1, pick_gap());
        send_poll(32'd1030, 1'b1, 1'b0, 1'b1, pick_gap());
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'h0000_0010, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'h0000_0390, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'h1234_5678, 1'b0, 1'b0, 1'b0, pick_gap());

        // Zero intervals: the first poll of a press still gives nothing.
        wait_idle();
        write_register(REG_REPEAT_INTERVAL, 16'd0);
        write_register(REG_LONG_PRESS, 16'd0);
        send_poll(32'd5, 1'b0, 1'b1, 1'b0, pick_gap());
        send_poll(32'd5, 1'b0, 1'b1, 1'b0, pick_gap());
        send_poll(32'd5, 1'b1, 1'b1, 1'b1, pick_gap());
        send_poll(32'd5, 1'b1, 1'b0, 1'b1, pick_gap());
        send_poll(32'd5, 1'b0, 1'b0, 1'b1, pick_gap());

        wait_idle();
        write_register(REG_REPEAT_INTERVAL, 16'hFFFF);
        write_register(REG_LONG_PRESS, 16'hFFFF);
        send_poll(32'h8000_0000, 1'b0, 1'b1, 1'b0, pick_gap());
        send_poll(32'h8000_FFFE, 1'b1, 1'b1, 1'b0, pick_gap());
        send_poll(32'h8000_FFFF, 1'b1, 1'b1, 1'b0, pick_gap());
        send_poll(32'h8001_0000, 1'b1, 1'b0, 1'b0, pick_gap());

        t = 32'd2000;
        key_left = 1'b0;
        key_enter = 1'b0;
        key_right = 1'b0;
        for (int phase = 0; phase < NumPhases; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    rep = RepeatReset;
                    lng = LongReset;
                    step_max = 60;
                end
                1: begin
                    rep = 16'd0;
                    lng = 16'd0;
                    step_max = 5;
                end
                2: begin
                    rep = 16'hFFFF;
                    lng = 16'hFFFF;
                    step_max = 20000;
                end
                3: begin
                    rep = 16'($urandom_range(0, 100));
                    lng = 16'($urandom_range(0, 300));
                    step_max = 40;
                end
                4: begin
                    rep = 16'($urandom);
                    lng = 16'($urandom);
                    step_max = 8000;
                end
                5: begin
                    rep = 16'd1;
                    lng = 16'd1;
                    step_max = 3;
                    t = 32'hFFFF_FF80;
                end
                default: begin
                    rep = 16'($urandom_range(0, 60));
                    lng = 16'($urandom_range(0, 200));
                    step_max = 30;
                end
            endcase
            write_register(REG_REPEAT_INTERVAL, rep);
            write_register(REG_LONG_PRESS, lng);
            if (phase == 3) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                if (phase == 3 && hold_req) begin
                    sender_burst = 1'b1;
                end else if ($urandom_range(0, 49) == 0) begin
                    sender_burst = !sender_burst;
                end
                if ($urandom_range(0, 99) < 4) begin
                    t = $urandom;
                    key_left = 1'($urandom_range(0, 1));
                    key_enter = 1'($urandom_range(0, 1));
                    key_right = 1'($urandom_range(0, 1));
                end else begin
                    if ($urandom_range(0, 7) == 0) begin
                        key_left = !key_left;
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        key_enter = !key_enter;
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        key_right = !key_right;
                    end
                    t = t + $urandom_range(0, step_max);
                end
                send_poll(t, key_left, key_enter, key_right, pick_gap());
            end
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
